FILE: sv/two_tier_transposition_table_assert.svh
// Assertion macros for the table's RTL.
`ifndef TWO_TIER_TRANSPOSITION_TABLE_ASSERT_SVH
`define TWO_TIER_TRANSPOSITION_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ttt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttt_pkg;

  localparam int MAX_INDEX_BITS_DEFAULT = 12;
  localparam logic [3:0] INDEX_BITS_RESET = 4'd12;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] NODE_LOWER = 2'd0;
  localparam logic [1:0] NODE_EXACT = 2'd1;
  localparam logic [1:0] NODE_UPPER = 2'd2;

  // Data word: depth 63:54, generation 53:51, bit 50 unused, type 49:48,
  // move 47:16, score 15:0.
  typedef struct packed {
    logic [9:0]  depth;
    logic [2:0]  gen;
    logic        spare;
    logic [1:0]  ntype;
    logic [31:0] move;
    logic [15:0] score;
  } entry_t;

  // The stored key stands in for the check word; both decode the same way
  // and a cleared slot reads as key zero.
  typedef struct packed {
    logic [63:0] key;
    entry_t      data;
  } slot_t;

endpackage

`default_nettype wire

FILE: sv/two_tier_transposition_table.sv
`timescale 1ns / 1ps
`default_nettype none
`include "two_tier_transposition_table_assert.svh"

// Channel   Handshake                    Payload
// item      item_valid / item_ready      operation, key, score, best_move,
//                                        node_type, generation, search_depth
// result    result_valid / result_ready  hit, found_score, found_move,
//                                        found_type, found_generation,
//                                        result_depth
// config    cfg_write                    cfg_data (index_bits)
//
// One item per cycle sustained while no clearing pass runs and results are
// taken; a result passes the slot stage and the result register. The figure
// is set by the single read-modify-write of the slot memories; a write to
// the entry just read is forwarded into the next item. After reset and after
// every config write, a clearing pass over all 2**MAX_INDEX_BITS slots zeroes
// both memories; item_ready is low meanwhile. A stalled result holds the item
// in the slot stage; nothing is written until the result register frees up.

module two_tier_transposition_table
  import ttt_pkg::*;
#(
  parameter int MAX_INDEX_BITS = MAX_INDEX_BITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [3:0]         cfg_data,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic               operation,
  input  wire logic [63:0]        key,
  input  wire logic signed [15:0] score,
  input  wire logic [31:0]        best_move,
  input  wire logic [1:0]         node_type,
  input  wire logic [2:0]         generation,
  input  wire logic [9:0]         search_depth,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic                    hit,
  output logic signed [15:0]      found_score,
  output logic [31:0]             found_move,
  output logic [1:0]              found_type,
  output logic [2:0]              found_generation,
  output logic [9:0]              result_depth
);

  localparam int IW = MAX_INDEX_BITS;

  logic [3:0]    index_bits;
  logic          clearing;
  logic [IW-1:0] clear_cnt;

  logic          s1_valid;
  logic          s1_op;
  logic [63:0]   s1_key;
  entry_t        s1_entry;
  logic [IW-1:0] s1_idx;
  logic          deep_fwd;
  logic          recent_fwd;
  slot_t         fwd_deep;
  slot_t         fwd_recent;

  logic [IW-1:0] idx_mask;
  logic [IW-1:0] in_idx;
  logic          accept;
  logic          s1_fire;

  slot_t         deep_q;
  slot_t         recent_q;
  slot_t         deep_cur;
  slot_t         recent_cur;

  logic          gen_diff;
  logic          keep_type;
  logic          keep_depth;
  logic          replace;

  logic          ins_deep_we;
  logic          ins_recent_we;
  slot_t         ins_deep_wdata;
  slot_t         ins_recent_wdata;

  logic          deep_we;
  logic          recent_we;
  logic [IW-1:0] waddr;
  slot_t         deep_wdata;
  slot_t         recent_wdata;

  logic          hit_deep;
  logic          hit_recent;

  // Index bits above the configured width are masked; widths beyond the
  // table saturate because the mask is only IW bits wide.
  always_comb begin
    for (int i = 0; i < IW; i++) begin
      idx_mask[i] = ({28'd0, index_bits} > 32'(i));
    end
  end

  assign in_idx     = key[IW-1:0] & idx_mask;
  assign s1_fire    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !clearing && (!s1_valid || s1_fire);
  assign accept     = item_valid && item_ready;

  assign deep_cur   = deep_fwd ? fwd_deep : deep_q;
  assign recent_cur = recent_fwd ? fwd_recent : recent_q;

  assign gen_diff   = deep_cur.data.gen != s1_entry.gen;
  assign keep_type  = (deep_cur.data.ntype != NODE_EXACT) || (s1_entry.ntype == NODE_EXACT)
                      || gen_diff;
  assign keep_depth = (deep_cur.data.depth <= s1_entry.depth) || gen_diff;
  assign replace    = keep_type && keep_depth;

  always_comb begin
    ins_deep_we      = 1'b0;
    ins_recent_we    = 1'b0;
    ins_deep_wdata   = '{key: s1_key, data: s1_entry};
    ins_recent_wdata = '{key: s1_key, data: s1_entry};
    if (s1_fire && (s1_op == OP_INSERT)) begin
      if (replace) begin
        ins_deep_we = 1'b1;
        // A copy of the same position in the always slot is dropped.
        if (recent_cur.key == s1_key) begin
          ins_recent_we    = 1'b1;
          ins_recent_wdata = '0;
        end
      end else if (deep_cur.key != recent_cur.key) begin
        ins_recent_we = 1'b1;
      end
    end
  end

  assign deep_we      = clearing || ins_deep_we;
  assign recent_we    = clearing || ins_recent_we;
  assign waddr        = clearing ? clear_cnt : s1_idx;
  assign deep_wdata   = clearing ? slot_t'('0) : ins_deep_wdata;
  assign recent_wdata = clearing ? slot_t'('0) : ins_recent_wdata;

  ttt_slot_ram #(
    .ADDR_W (IW)
  ) u_deep_ram (
    .clk   (clk),
    .we    (deep_we),
    .waddr (waddr),
    .wdata (deep_wdata),
    .re    (accept),
    .raddr (in_idx),
    .rdata (deep_q)
  );

  ttt_slot_ram #(
    .ADDR_W (IW)
  ) u_recent_ram (
    .clk   (clk),
    .we    (recent_we),
    .waddr (waddr),
    .wdata (recent_wdata),
    .re    (accept),
    .raddr (in_idx),
    .rdata (recent_q)
  );

  // Configuration and clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= INDEX_BITS_RESET;
      clearing   <= 1'b1;
      clear_cnt  <= '0;
    end else if (cfg_write) begin
      index_bits <= cfg_data;
      clearing   <= 1'b1;
      clear_cnt  <= '0;
    end else if (clearing) begin
      clear_cnt <= clear_cnt + IW'(1);
      if (clear_cnt == {IW{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  // Slot stage: holds the item while its entry is read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      deep_fwd   <= 1'b0;
      recent_fwd <= 1'b0;
    end else if (accept) begin
      s1_valid   <= 1'b1;
      deep_fwd   <= ins_deep_we && (s1_idx == in_idx);
      recent_fwd <= ins_recent_we && (s1_idx == in_idx);
    end else if (s1_fire) begin
      s1_valid   <= 1'b0;
      deep_fwd   <= 1'b0;
      recent_fwd <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op          <= operation;
      s1_key         <= key;
      s1_idx         <= in_idx;
      s1_entry.score <= score;
      s1_entry.move  <= best_move;
      s1_entry.ntype <= node_type;
      s1_entry.spare <= 1'b0;
      s1_entry.gen   <= generation;
      s1_entry.depth <= search_depth;
      fwd_deep       <= ins_deep_wdata;
      fwd_recent     <= ins_recent_wdata;
    end
  end

  assign hit_deep   = deep_cur.key == s1_key;
  assign hit_recent = recent_cur.key == s1_key;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      hit              <= 1'b0;
      found_score      <= '0;
      found_move       <= '0;
      found_type       <= '0;
      found_generation <= '0;
      result_depth     <= '0;
      if (s1_op == OP_INSERT) begin
        result_depth <= s1_entry.depth;
      end else if (hit_deep) begin
        hit              <= 1'b1;
        found_score      <= deep_cur.data.score;
        found_move       <= deep_cur.data.move;
        found_type       <= deep_cur.data.ntype;
        found_generation <= deep_cur.data.gen;
        result_depth     <= deep_cur.data.depth;
      end else if (hit_recent) begin
        hit              <= 1'b1;
        found_score      <= recent_cur.data.score;
        found_move       <= recent_cur.data.move;
        found_type       <= recent_cur.data.ntype;
        found_generation <= recent_cur.data.gen;
        result_depth     <= recent_cur.data.depth;
      end
    end
  end

  `TTT_ASSERT_NOW(a_no_item_while_clearing, item_ready, !clearing,
                  "item taken during clearing")
  `TTT_ASSERT_NEXT(a_cfg_starts_clear, cfg_write, clearing && (clear_cnt == '0),
                   "no clear after config")
  `TTT_ASSERT_NOW(a_fwd_needs_stage, deep_fwd || recent_fwd, s1_valid,
                  "forward without item")
  `TTT_ASSERT_NOW(a_stall_no_write, result_valid && !result_ready,
                  !ins_deep_we && !ins_recent_we, "table written while result stalled")

endmodule

`default_nettype wire

FILE: sv/ttt_slot_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ttt_slot_ram
  import ttt_pkg::*;
#(
  parameter int ADDR_W = MAX_INDEX_BITS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire slot_t             wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output slot_t                  rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  slot_t mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_two_tier_transposition_table.sv
`timescale 1ns / 1ps

module tb_two_tier_transposition_table;
  import ttt_pkg::*;

  localparam int TABLE_SIZE = 1 << MAX_INDEX_BITS_DEFAULT;
  localparam int KEY_POOL = 16;
  localparam int LONG_HOLD = 300;
  localparam int MAX_REPORTS = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic               op;
    logic [63:0]        key;
    logic signed [15:0] score;
    logic [31:0]        move;
    logic [1:0]         ntype;
    logic [2:0]         gen;
    logic [9:0]         depth;
  } probe_t;

  typedef struct packed {
    logic               is_hit;
    logic signed [15:0] score;
    logic [31:0]        move;
    logic [1:0]         ntype;
    logic [2:0]         gen;
    logic [9:0]         depth;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [3:0]         cfg_data = '0;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic               operation = OP_INSERT;
  logic [63:0]        key = '0;
  logic signed [15:0] score = '0;
  logic [31:0]        best_move = '0;
  logic [1:0]         node_type = NODE_LOWER;
  logic [2:0]         generation = '0;
  logic [9:0]         search_depth = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic               hit;
  logic signed [15:0] found_score;
  logic [31:0]        found_move;
  logic [1:0]         found_type;
  logic [2:0]         found_generation;
  logic [9:0]         result_depth;

  two_tier_transposition_table dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .operation        (operation),
    .key              (key),
    .score            (score),
    .best_move        (best_move),
    .node_type        (node_type),
    .generation       (generation),
    .search_depth     (search_depth),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .hit              (hit),
    .found_score      (found_score),
    .found_move       (found_move),
    .found_type       (found_type),
    .found_generation (found_generation),
    .result_depth     (result_depth)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Table copy kept by the testbench. Slots hold the stored key directly;
  // a cleared slot reads back as key zero with all-zero data.
  logic [3:0]  width_setting;
  entry_t      deep_data [TABLE_SIZE];
  logic [63:0] deep_key [TABLE_SIZE];
  entry_t      recent_data [TABLE_SIZE];
  logic [63:0] recent_key [TABLE_SIZE];

  probe_t      pending_items[$];
  answer_t     expected_results[$];
  probe_t      offered;
  answer_t     got_answer;
  answer_t     want_answer;
  logic [63:0] key_pool [KEY_POOL];
  logic [2:0]  phase_gen = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_kick = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned inserts_done = 0;
  int unsigned lookups_done = 0;
  int unsigned hits_seen = 0;
  int unsigned widths_tried = 0;

  function automatic void set_index_bits(input logic [3:0] bits);
    width_setting = bits;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      deep_data[i] = '0;
      deep_key[i] = '0;
      recent_data[i] = '0;
      recent_key[i] = '0;
    end
  endfunction

  function automatic answer_t tt_access(input probe_t p);
    int unsigned width;
    logic [MAX_INDEX_BITS_DEFAULT-1:0] slot;
    entry_t fresh;
    entry_t old;
    entry_t found;
    logic gen_moved;
    answer_t a;
    width = (width_setting > MAX_INDEX_BITS_DEFAULT) ? MAX_INDEX_BITS_DEFAULT : width_setting;
    slot = p.key[MAX_INDEX_BITS_DEFAULT-1:0]
         & (({{(MAX_INDEX_BITS_DEFAULT-1){1'b0}}, 1'b1} << width) - 1'b1);
    a = '0;
    if (p.op == OP_INSERT) begin
      fresh = '{depth: p.depth, gen: p.gen, spare: 1'b0, ntype: p.ntype,
                move: p.move, score: p.score};
      old = deep_data[slot];
      gen_moved = old.gen != fresh.gen;
      if ((old.ntype != NODE_EXACT || fresh.ntype == NODE_EXACT || gen_moved) &&
          (old.depth <= fresh.depth || gen_moved)) begin
        deep_data[slot] = fresh;
        deep_key[slot] = p.key;
        if (recent_key[slot] == p.key) begin
          recent_data[slot] = '0;
          recent_key[slot] = '0;
        end
      end else if (deep_key[slot] != recent_key[slot]) begin
        recent_data[slot] = fresh;
        recent_key[slot] = p.key;
      end
      a.depth = fresh.depth;
    end else begin
      found = '0;
      if (deep_key[slot] == p.key) begin
        a.is_hit = 1'b1;
        found = deep_data[slot];
      end else if (recent_key[slot] == p.key) begin
        a.is_hit = 1'b1;
        found = recent_data[slot];
      end
      if (a.is_hit) begin
        a.score = found.score;
        a.move = found.move;
        a.ntype = found.ntype;
        a.gen = found.gen;
        a.depth = found.depth;
      end
    end
    return a;
  endfunction

  // Input side: one item per beat, payload held until accepted.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        expected_results.push_back(tt_access(offered));
        if (offered.op == OP_INSERT) inserts_done++;
        else lookups_done++;
      end
      if (!item_valid || item_ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = pending_items.pop_front();
          item_valid <= 1'b1;
          operation <= offered.op;
          key <= offered.key;
          score <= offered.score;
          best_move <= offered.move;
          node_type <= offered.ntype;
          generation <= offered.gen;
          search_depth <= offered.depth;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by toggling hold_kick.
  always @(posedge clk) begin
    if (rst) begin
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic report_bad(input string what, input answer_t want, input answer_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%s at cycle %0d", what, cycle_count);
      $display("  expected hit=%0d score=%0d move=%h type=%0d gen=%0d depth=%0d",
               want.is_hit, want.score, want.move, want.ntype, want.gen, want.depth);
      $display("  actual   hit=%0d score=%0d move=%h type=%0d gen=%0d depth=%0d",
               got.is_hit, got.score, got.move, got.ntype, got.gen, got.depth);
    end
  endtask

  // Result side.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        got_answer = '{is_hit: hit, score: found_score, move: found_move,
                       ntype: found_type, gen: found_generation, depth: result_depth};
        if (expected_results.size() == 0) begin
          report_bad("result beat with nothing outstanding", '0, got_answer);
        end else begin
          want_answer = expected_results.pop_front();
          if (want_answer.is_hit) hits_seen++;
          if (got_answer.is_hit !== want_answer.is_hit ||
              got_answer.score !== want_answer.score ||
              got_answer.move !== want_answer.move ||
              got_answer.ntype !== want_answer.ntype ||
              got_answer.gen !== want_answer.gen ||
              got_answer.depth !== want_answer.depth) begin
            report_bad("result mismatch", want_answer, got_answer);
          end
        end
      end
      result_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d items pending and %0d results outstanding",
               pending_items.size(), expected_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic add_insert(input logic [63:0] k, input logic signed [15:0] s,
                            input logic [31:0] m, input logic [1:0] t,
                            input logic [2:0] g, input logic [9:0] d);
    probe_t p;
    p = '{op: OP_INSERT, key: k, score: s, move: m, ntype: t, gen: g, depth: d};
    pending_items.push_back(p);
  endtask

  task automatic add_lookup(input logic [63:0] k);
    probe_t p;
    p = '{op: OP_LOOKUP, key: k, score: 16'($urandom), move: $urandom,
          ntype: 2'($urandom_range(0, 3)), gen: 3'($urandom_range(0, 7)),
          depth: 10'($urandom_range(0, 1023))};
    pending_items.push_back(p);
  endtask

  function automatic void refill_key_pool();
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
    phase_gen = 3'($urandom_range(0, 7));
  endfunction

  // Keys favor reuse and index collisions so that both slots see traffic.
  task automatic queue_random(input int unsigned count);
    probe_t p;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      p.key = {$urandom, $urandom};
      if (pick < 35) p.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      else if (pick < 55) p.key[11:0] = key_pool[$urandom_range(0, KEY_POOL - 1)][11:0];
      else if (pick < 60) p.key = '0;
      p.op = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_LOOKUP;
      p.score = 16'($urandom);
      p.move = $urandom;
      p.ntype = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 4) phase_gen = phase_gen + 3'd1;
      p.gen = ($urandom_range(0, 99) < 75) ? phase_gen : 3'($urandom_range(0, 7));
      p.depth = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 15))
                                             : 10'($urandom_range(0, 1023));
      pending_items.push_back(p);
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_index_bits(input logic [3:0] bits);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= bits;
    @(posedge clk);
    cfg_write <= 1'b0;
    set_index_bits(bits);
    widths_tried++;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [3:0] bits, input int unsigned send_pct,
                           input int unsigned stall_pct, input int unsigned count);
    wait_drained();
    write_index_bits(bits);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    refill_key_pool();
    queue_random(count);
  endtask

  localparam logic [63:0] KEY_A = 64'h0123_4567_89ab_c5a5;
  localparam logic [63:0] KEY_B = KEY_A ^ (64'd1 << 40);
  localparam logic [63:0] KEY_C = 64'hfedc_ba98_7654_3abc;

  initial begin
    set_index_bits(INDEX_BITS_RESET);
    widths_tried = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty table: key zero matches a cleared slot, other keys miss.
    add_lookup(64'd0);
    add_lookup(KEY_A);
    add_insert(KEY_A, -16'sd32768, 32'hffff_ffff, NODE_EXACT, 3'd7, 10'd1023);
    add_lookup(KEY_A);
    // Shallower non-exact entry of the same generation lands in the always slot.
    add_insert(KEY_A, 16'sd32767, 32'h0, NODE_LOWER, 3'd7, 10'd0);
    add_lookup(KEY_A);
    add_insert(KEY_B, 16'sd1, 32'h1, NODE_EXACT, 3'd7, 10'd1023);
    add_lookup(KEY_A);
    add_lookup(KEY_B);
    // A new generation takes the depth slot and clears the matching always slot.
    add_insert(KEY_A, -16'sd1, 32'h5555_aaaa, NODE_UPPER, 3'd3, 10'd5);
    add_lookup(KEY_B);
    add_lookup(KEY_A);
    add_insert(64'd0, 16'sd32767, 32'h0, NODE_EXACT, 3'd0, 10'd1023);
    // Both slots hold key zero here, so the always slot is not written.
    add_insert(64'h1000, 16'sd5, 32'h5, NODE_LOWER, 3'd0, 10'd1);
    add_insert(64'h2000, 16'sd6, 32'h6, 2'd3, 3'd0, 10'd1023);
    add_lookup(64'h1000);
    add_lookup(64'd0);
    // Node type three is stored as given and does not protect the slot.
    add_insert(KEY_C, 16'sd100, 32'haaaa_5555, 2'd3, 3'd2, 10'd500);
    add_insert(KEY_C ^ (64'd1 << 30), 16'sd200, 32'h7, NODE_LOWER, 3'd2, 10'd400);
    add_lookup(KEY_C);
    add_lookup(KEY_C ^ (64'd1 << 30));
    add_insert(KEY_C ^ (64'd1 << 31), 16'sd300, 32'h8, NODE_UPPER, 3'd2, 10'd500);
    add_lookup(KEY_C);
    add_lookup(KEY_C ^ (64'd1 << 30));

    run_phase(4'd1, 0, 0, 110);
    run_phase(4'd0, 84, 0, 100);
    run_phase(4'd15, 0, 84, 100);
    run_phase(4'd4, 19, 19, 110);

    // The receiver holds off while items keep coming, so the input stalls.
    // The hold starts once the clearing pass is over and beats are flowing.
    run_phase(4'd12, 0, 0, 60);
    while (expected_results.size() == 0) @(negedge clk);
    hold_kick = ~hold_kick;
    wait_drained();
    send_idle_pct = 19;
    recv_stall_pct = 19;
    queue_random(30);
    wait_drained();
    queue_random(30);

    run_phase(4'd13, 0, 84, 80);
    run_phase(4'd2, 84, 0, 80);
    wait_drained();

    $display("Covered %0d inserts and %0d lookups (%0d expected hits) over %0d index widths,",
             inserts_done, lookups_done, hits_seen, widths_tried);
    $display("with idle gaps, receiver stalls, a long hold-off and mid-run pauses.");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d errors", error_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/ttt_pkg.sv
sv/ttt_slot_ram.sv
sv/two_tier_transposition_table.sv
tb/sv/tb_two_tier_transposition_table.sv
